// ===== rtl/core/first_minimum_parabolic_finder_top_assert.svh =====
// ----------------------------------------------------------------------------
// first_minimum_parabolic_finder_top_assert.svh
// assertion macros shared by the finder's checking code
// ----------------------------------------------------------------------------
`ifndef FIRST_MINIMUM_PARABOLIC_FINDER_TOP_ASSERT_SVH
`define FIRST_MINIMUM_PARABOLIC_FINDER_TOP_ASSERT_SVH

// consequence checked in the same cycle as the antecedent
`define FMPF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define FMPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fmpf_pkg.sv =====
// ----------------------------------------------------------------------------
// fmpf_pkg
// shared widths, register indexes and helpers of the first minimum finder
// ----------------------------------------------------------------------------
package fmpf_pkg;

  // default histogram length
  localparam int MAX_BINS_DEF = 1024;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // divider widths: |w*(gl-gn)| < 2^63, |2*(2g0-gn-gl)| < 2^35
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 35;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // wide position arithmetic before saturation
  localparam int POS_W = PROD_W;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIRST_CENTER = 2'd0,
    CFG_BIN_STEP     = 2'd1,
    CFG_CLAMP_LEVEL  = 2'd2,
    CFG_ACCEPT_LEVEL = 2'd3
  } cfg_idx_t;

  // register reset values
  localparam logic signed [31:0] FIRST_CENTER_RST = 32'sd0;
  localparam logic [30:0]        BIN_STEP_RST     = 31'd65536;
  localparam logic [31:0]        CLAMP_LEVEL_RST  = 32'd805306368;
  localparam logic [31:0]        ACCEPT_LEVEL_RST = 32'd268435456;

  // saturate a wide position to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] lo;
    hi = POS_W'(32'sh7FFF_FFFF);
    lo = POS_W'(-33'sd2147483648);
    if (v > hi) begin
      return 32'h7FFF_FFFF;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/first_minimum_parabolic_finder_top.sv =====
// ----------------------------------------------------------------------------
// first_minimum_parabolic_finder_top
// first local minimum of a streamed squared-modulus histogram, located by a
// three-point parabolic fit
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries one complex bin per transfer,
//   re_part/im_part in Q2.30, last_bin marking the end of a histogram.
//   out channel (out_valid/out_ready) gives one result per histogram, on the
//   transfer of the bin marked last: position Q16.16, found, one-based bin
//   index and the flat-fit flag; all zero when no minimum was found.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
//   registers; cfg_ready is always high, write only while the block is idle.
// Sequence:
//   each bin passes the squaring, magnitude, test and finish steps before
//   the next in_ready; the squared modulus goes twice through the single
//   shared multiplier. a bin completing a minimum also passes the x0 multiply,
//   numerator multiply, divider load, bit-serial divide and fix-up (unless flat).
//   the result is valid the cycle after the last bin's work ends.
// Reset clears the histogram state and loads register defaults. When the
// receiver stalls, the result is held and a further last bin waits in its
// final step until the output register is free; other bins keep flowing.
// ----------------------------------------------------------------------------
module first_minimum_parabolic_finder_top #(
  parameter int MAX_BINS = fmpf_pkg::MAX_BINS_DEF,
  localparam int CNT_W = $clog2(MAX_BINS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  // input bins
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  re_part,
  input  logic signed [31:0]  im_part,
  input  logic                last_bin,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  root_position,
  output logic                found,
  output logic [CNT_W-1:0]    minimum_bin,
  output logic                flat_fit,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_SQ_RE    = 11'b000_0000_0010,
    ST_SQ_IM    = 11'b000_0000_0100,
    ST_MAG      = 11'b000_0000_1000,
    ST_TEST     = 11'b000_0001_0000,
    ST_X0_MUL   = 11'b000_0010_0000,
    ST_NUM_MUL  = 11'b000_0100_0000,
    ST_DIV_LOAD = 11'b000_1000_0000,
    ST_DIVIDE   = 11'b001_0000_0000,
    ST_FIXUP    = 11'b010_0000_0000,
    ST_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [31:0]  first_center;
  logic [30:0]         bin_step;
  logic [31:0]         clamp_level;
  logic [31:0]         accept_level;

  // captured bin
  logic signed [31:0]  re_reg;
  logic signed [31:0]  im_reg;
  logic                last_reg;

  // magnitude and histogram state
  logic [63:0]         acc;
  logic [31:0]         mag;
  logic [31:0]         win [0:2];
  logic [CNT_W-1:0]    bin_counter;
  logic                found_flag;
  logic [31:0]         held_position;
  logic [CNT_W-1:0]    held_index;
  logic                held_flat;

  // fit operands
  logic signed [32:0]               diff;
  logic signed [35:0]               div_reg;
  logic [CNT_W-1:0]                 fit_idx;
  logic signed [fmpf_pkg::POS_W-1:0] x0;
  logic                             q_neg;

  // shared units
  logic signed [fmpf_pkg::MUL_W-1:0]   mul_a;
  logic signed [fmpf_pkg::MUL_W-1:0]   mul_b;
  logic signed [fmpf_pkg::PROD_W-1:0]  mul_p;
  logic                                div_start;
  logic [fmpf_pkg::DIVIDEND_W-1:0]     div_dividend;
  logic [fmpf_pkg::DIVISOR_W-1:0]      div_divisor;
  logic [fmpf_pkg::DIVIDEND_W-1:0]     div_quotient;
  logic                                div_done;

  // combinational helpers
  logic [63:0]                      sq;
  logic [31:0]                      g_raw;
  logic                             hit;
  logic signed [35:0]               div_calc;
  logic [CNT_W-1:0]                 fit_m1;
  logic                             num_neg;
  logic [63:0]                      num_mag;
  logic [35:0]                      div_abs;
  logic signed [fmpf_pkg::POS_W-1:0] q_signed;
  logic signed [fmpf_pkg::POS_W-1:0] pos_wide;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // shared multiplier operand selection
  always_comb begin
    fit_m1 = fit_idx - CNT_W'(1);
    case (state)
      ST_SQ_RE: begin
        mul_a = {re_reg[31], re_reg};
        mul_b = {re_reg[31], re_reg};
      end
      ST_SQ_IM: begin
        mul_a = {im_reg[31], im_reg};
        mul_b = {im_reg[31], im_reg};
      end
      ST_X0_MUL: begin
        mul_a = fmpf_pkg::MUL_W'(fit_m1);
        mul_b = {2'b00, bin_step};
      end
      ST_NUM_MUL: begin
        mul_a = diff;
        mul_b = {2'b00, bin_step};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fmpf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // squared modulus, minimum test and divider operands
  always_comb begin
    sq       = acc + mul_p[63:0];
    g_raw    = sq[63:32];
    hit      = (bin_counter >= CNT_W'(3)) && !found_flag &&
               (win[2] > win[1]) && (mag > win[1]) && (win[1] < accept_level);
    div_calc = ($signed({4'b0000, win[1]}) <<< 1) - $signed({4'b0000, win[2]})
               - $signed({4'b0000, win[0]});
    num_neg  = mul_p[fmpf_pkg::PROD_W-1];
    num_mag  = num_neg ? (64'd0 - mul_p[63:0]) : mul_p[63:0];
    div_abs  = div_reg[35] ? (36'd0 - div_reg) : div_reg;
    q_signed = q_neg ? -$signed({2'b00, div_quotient}) : $signed({2'b00, div_quotient});
    pos_wide = x0 - q_signed;
  end

  assign div_start    = (state == ST_DIV_LOAD) && (div_reg != 36'sd0);
  assign div_dividend = num_mag;
  assign div_divisor  = div_abs[fmpf_pkg::DIVISOR_W-1:0];

  fmpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_center <= fmpf_pkg::FIRST_CENTER_RST;
      bin_step     <= fmpf_pkg::BIN_STEP_RST;
      clamp_level  <= fmpf_pkg::CLAMP_LEVEL_RST;
      accept_level <= fmpf_pkg::ACCEPT_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fmpf_pkg::CFG_FIRST_CENTER: first_center <= cfg_data;
        fmpf_pkg::CFG_BIN_STEP:     bin_step     <= cfg_data[30:0];
        fmpf_pkg::CFG_CLAMP_LEVEL:  clamp_level  <= cfg_data;
        fmpf_pkg::CFG_ACCEPT_LEVEL: accept_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        re_reg   <= re_part;
        im_reg   <= im_part;
      end
      ST_SQ_IM: begin
        acc <= mul_p[63:0];
      end
      ST_MAG: begin
        mag <= (g_raw > clamp_level) ? 32'd0 : g_raw;
      end
      ST_TEST: begin
        diff    <= $signed({1'b0, win[0]}) - $signed({1'b0, win[2]});
        div_reg <= div_calc <<< 1;
        fit_idx <= bin_counter - CNT_W'(1);
      end
      ST_NUM_MUL: begin
        x0 <= $signed({{(fmpf_pkg::POS_W-32){first_center[31]}}, first_center}) + mul_p;
      end
      ST_DIV_LOAD: begin
        q_neg <= num_neg ^ div_reg[35];
      end
      default: ;
    endcase
  end

  // sequencer and histogram state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      last_reg      <= 1'b0;
      win[0]        <= '0;
      win[1]        <= '0;
      win[2]        <= '0;
      bin_counter   <= '0;
      found_flag    <= 1'b0;
      held_position <= '0;
      held_index    <= '0;
      held_flat     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // result taken by the receiver, unless a new one is loaded
      if (out_valid && out_ready && !((state == ST_FINISH) && last_reg)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last_reg <= last_bin;
            state    <= ST_SQ_RE;
          end
        end
        ST_SQ_RE:  state <= ST_SQ_IM;
        ST_SQ_IM:  state <= ST_MAG;
        ST_MAG:    state <= ST_TEST;
        // minimum test and window shift; late bins are ignored
        ST_TEST: begin
          if (bin_counter < CNT_W'(MAX_BINS)) begin
            win[0]      <= win[1];
            win[1]      <= win[2];
            win[2]      <= mag;
            bin_counter <= bin_counter + CNT_W'(1);
            if (hit) begin
              found_flag <= 1'b1;
              held_index <= bin_counter - CNT_W'(1);
              state      <= ST_X0_MUL;
            end else begin
              state <= ST_FINISH;
            end
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_X0_MUL:  state <= ST_NUM_MUL;
        ST_NUM_MUL: state <= ST_DIV_LOAD;
        // flat parabola returns the bin centre, any other fit goes to the divider
        ST_DIV_LOAD: begin
          if (div_reg == 36'sd0) begin
            held_position <= fmpf_pkg::sat32(x0);
            held_flat     <= 1'b1;
            state         <= ST_FINISH;
          end else begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_FIXUP;
          end
        end
        ST_FIXUP: begin
          held_position <= fmpf_pkg::sat32(pos_wide);
          held_flat     <= 1'b0;
          state         <= ST_FINISH;
        end
        // report on the last bin and clear the histogram
        ST_FINISH: begin
          if (!last_reg) begin
            state <= ST_IDLE;
          end else if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            root_position <= found_flag ? held_position : 32'd0;
            found         <= found_flag;
            minimum_bin   <= found_flag ? held_index : '0;
            flat_fit      <= found_flag && held_flat;
            win[0]        <= '0;
            win[1]        <= '0;
            win[2]        <= '0;
            bin_counter   <= '0;
            found_flag    <= 1'b0;
            held_position <= '0;
            held_index    <= '0;
            held_flat     <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `include "first_minimum_parabolic_finder_top_assert.svh"

  `FMPF_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "ready after transfer")
  `FMPF_ASSERT_SAME(a_divide_has_fit, state == ST_DIVIDE, found_flag && (div_reg != 36'sd0), "divide without fit")
  `FMPF_ASSERT_SAME(a_none_is_zero, out_valid && !found, (root_position == 32'sd0) && (minimum_bin == '0) && !flat_fit, "non-zero empty result")
  `FMPF_ASSERT_SAME(a_result_from_last, $rose(out_valid), $past(state == ST_FINISH) && $past(last_reg), "result not from last bin")

endmodule

// ===== rtl/core/fmpf_mul.sv =====
// ----------------------------------------------------------------------------
// fmpf_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module fmpf_mul (
  input  logic                                 clk,
  input  logic signed [fmpf_pkg::MUL_W-1:0]    a,
  input  logic signed [fmpf_pkg::MUL_W-1:0]    b,
  output logic signed [fmpf_pkg::PROD_W-1:0]   p
);

  // one product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/core/fmpf_div.sv =====
// ----------------------------------------------------------------------------
// fmpf_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fmpf_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [fmpf_pkg::DIVIDEND_W-1:0]       dividend,
  input  logic [fmpf_pkg::DIVISOR_W-1:0]        divisor,
  output logic [fmpf_pkg::DIVIDEND_W-1:0]       quotient,
  output logic                                  done
);

  logic [fmpf_pkg::DIVISOR_W-1:0]   rem;
  logic [fmpf_pkg::DIVIDEND_W-1:0]  quo;
  logic [fmpf_pkg::DIVISOR_W-1:0]   dsr;
  logic [fmpf_pkg::DIV_CNT_W-1:0]   count;
  logic                             busy;
  logic [fmpf_pkg::DIVISOR_W:0]     shifted;
  logic [fmpf_pkg::DIVISOR_W+1:0]   trial;
  logic                             fits;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quo[fmpf_pkg::DIVIDEND_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr};
    fits    = !trial[fmpf_pkg::DIVISOR_W+1];
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == fmpf_pkg::DIV_CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= fmpf_pkg::DIV_CNT_W'(fmpf_pkg::DIVIDEND_W);
      end else if (busy) begin
        count <= count - fmpf_pkg::DIV_CNT_W'(1);
        if (count == fmpf_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[fmpf_pkg::DIVISOR_W-1:0] : shifted[fmpf_pkg::DIVISOR_W-1:0];
      quo <= {quo[fmpf_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== tb/sv/first_minimum_checker.sv =====
// ----------------------------------------------------------------------------
// first_minimum_checker
// watches the bin, result and register channels of the first minimum finder,
// predicts the result of every histogram and compares it with what comes out
// ----------------------------------------------------------------------------
module first_minimum_checker
  import fmpf_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF,
  localparam int CNT_W = $clog2(MAX_BINS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic signed [31:0]  re_part,
  input  logic signed [31:0]  im_part,
  input  logic                last_bin,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [31:0]  root_position,
  input  logic                found,
  input  logic [CNT_W-1:0]    minimum_bin,
  input  logic                flat_fit,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0]      position;
    logic             hit;
    logic [CNT_W-1:0] bin;
    logic             flat;
  } root_report_t;

  // register copies
  logic signed [31:0] centre_reg;
  logic [30:0]        step_reg;
  logic [31:0]        clamp_reg;
  logic [31:0]        accept_reg;

  // per-histogram state
  logic [31:0]        mag_hist [3];
  int                 bins_seen;
  logic               have_min;
  logic [31:0]        min_pos;
  logic [CNT_W-1:0]   min_bin;
  logic               min_flat;

  root_report_t       expected_roots [$];
  root_report_t       oldest;
  int                 fault_total = 0;

  // clip a wide Q16.16 position to 32 bits
  function automatic logic [31:0] saturate_q16(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic restart_histogram();
    mag_hist[0] = '0;
    mag_hist[1] = '0;
    mag_hist[2] = '0;
    bins_seen   = 0;
    have_min    = 1'b0;
    min_pos     = '0;
    min_bin     = '0;
    min_flat    = 1'b0;
  endtask

  // one bin in, possibly one report out on the last bin
  task automatic advance_histogram(input logic signed [31:0] re, input logic signed [31:0] im,
                                   input logic last);
    longint       re_w, im_w, gl, g0, gn, w, x0, divisor, numer, bidx;
    logic [63:0]  power;
    logic [31:0]  g;
    int           n;
    root_report_t rep;
    re_w  = re;
    im_w  = im;
    power = re_w * re_w + im_w * im_w;
    g     = power[63:32];
    if (g > clamp_reg) g = '0;

    // late bins only count for the last mark
    if (bins_seen < MAX_BINS) begin
      n = bins_seen + 1;
      if (n >= 4 && !have_min) begin
        if (mag_hist[2] > mag_hist[1] && g > mag_hist[1] && mag_hist[1] < accept_reg) begin
          gl       = mag_hist[0];
          g0       = mag_hist[1];
          gn       = mag_hist[2];
          w        = step_reg;
          bidx     = n - 2;
          x0       = centre_reg;
          x0       = x0 + (bidx - 1) * w;
          divisor  = 2 * (2 * g0 - gn - gl);
          have_min = 1'b1;
          min_bin  = CNT_W'(bidx);
          if (divisor == 0) begin
            min_pos  = saturate_q16(x0);
            min_flat = 1'b1;
          end else begin
            numer    = w * (gl - gn);
            min_pos  = saturate_q16(x0 - numer / divisor);
            min_flat = 1'b0;
          end
        end
      end
      mag_hist[0] = mag_hist[1];
      mag_hist[1] = mag_hist[2];
      mag_hist[2] = g;
      bins_seen   = n;
    end

    if (last) begin
      rep.position = have_min ? min_pos : '0;
      rep.hit      = have_min;
      rep.bin      = have_min ? min_bin : '0;
      rep.flat     = have_min && min_flat;
      expected_roots.push_back(rep);
      restart_histogram();
    end
  endtask

  // monitor and compare on every rising edge
  always @(posedge clk) begin
    if (rst) begin
      centre_reg = FIRST_CENTER_RST;
      step_reg   = BIN_STEP_RST;
      clamp_reg  = CLAMP_LEVEL_RST;
      accept_reg = ACCEPT_LEVEL_RST;
      restart_histogram();
      expected_roots.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FIRST_CENTER: centre_reg = cfg_data;
          CFG_BIN_STEP:     step_reg   = cfg_data[30:0];
          CFG_CLAMP_LEVEL:  clamp_reg  = cfg_data;
          CFG_ACCEPT_LEVEL: accept_reg = cfg_data;
          default: ;
        endcase
      end

      // result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          fault_total++;
          if (fault_total <= 10)
            $display("%0t: result with nothing expected: pos=%h found=%b bin=%0d flat=%b",
                     $realtime, root_position, found, minimum_bin, flat_fit);
        end else begin
          oldest = expected_roots.pop_front();
          if (root_position !== oldest.position || found !== oldest.hit ||
              minimum_bin !== oldest.bin || flat_fit !== oldest.flat) begin
            fault_total++;
            if (fault_total <= 10)
              $display("%0t: result mismatch: expected pos=%h found=%b bin=%0d flat=%b, got pos=%h found=%b bin=%0d flat=%b",
                       $realtime, oldest.position, oldest.hit, oldest.bin, oldest.flat,
                       root_position, found, minimum_bin, flat_fit);
          end
        end
      end

      // bin transfer
      if (in_valid && in_ready) advance_histogram(re_part, im_part, last_bin);
    end
    mismatches <= fault_total;
    pending    <= expected_roots.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the first minimum parabolic finder: directed
// histograms for the corner cases, then random valley-shaped and noise
// histograms over several register settings and idling patterns
// ----------------------------------------------------------------------------
module tb_top;
  import fmpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BIN_W          = $clog2(MAX_BINS_DEF + 1);
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int SEGMENTS       = 6;
  localparam int SEGMENT_BINS   = 100;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] re_part = '0;
  logic signed [31:0] im_part = '0;
  logic               last_bin = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] root_position;
  logic               found;
  logic [BIN_W-1:0]   minimum_bin;
  logic               flat_fit;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 mismatches;
  int                 pending;
  int                 in_gap_pct = 36;
  int                 out_stall_pct = 46;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  first_minimum_parabolic_finder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .re_part       (re_part),
    .im_part       (im_part),
    .last_bin      (last_bin),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .root_position (root_position),
    .found         (found),
    .minimum_bin   (minimum_bin),
    .flat_fit      (flat_fit),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  first_minimum_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .re_part       (re_part),
    .im_part       (im_part),
    .last_bin      (last_bin),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .root_position (root_position),
    .found         (found),
    .minimum_bin   (minimum_bin),
    .flat_fit      (flat_fit),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // end the run when no channel has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // one bin transfer, with random gaps in front of it
  task automatic send_bin(input logic signed [31:0] re, input logic signed [31:0] im,
                          input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    re_part  <= re;
    im_part  <= im;
    last_bin <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // amplitude a in units of 2^-14 gives a squared modulus of about a*a lsb
  function automatic logic signed [31:0] scaled_part(input int amp, input bit dither);
    logic signed [31:0] v;
    v = amp * 65536;
    if (dither) v = v + $urandom_range(0, 65535);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_amp(input int amp, input logic last);
    send_bin(scaled_part(amp, 1'b0), 32'sd0, last);
  endtask

  // histogram falling towards low_bin and rising after it, with jitter
  task automatic send_valley(input int len, input int low_bin);
    int                 amp_floor, slope, amp, span, k;
    logic signed [31:0] a_part, b_part;
    amp_floor = $urandom_range(0, 24000);
    slope     = $urandom_range(1, 4000);
    a_part    = '0;
    b_part    = '0;
    for (k = 0; k < len; k++) begin
      // occasional exact repeat of the previous bin
      if (k == 0 || $urandom_range(0, 7) != 0) begin
        span = (k > low_bin) ? k - low_bin : low_bin - k;
        amp  = amp_floor + slope * span + $urandom_range(0, slope);
        if (amp > 32767) amp = 32767;
        a_part = scaled_part(amp, $urandom_range(0, 1));
        b_part = $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) b_part = -b_part;
      end
      if ($urandom_range(0, 3) == 0)
        send_bin(b_part, a_part, k == len - 1);
      else
        send_bin(a_part, b_part, k == len - 1);
    end
  endtask

  task automatic send_noise(input int len);
    int k;
    for (k = 0; k < len; k++) send_bin($urandom, $urandom, k == len - 1);
  endtask

  // drop valid, let every result come out and the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] centre, input logic [31:0] step,
                               input logic [31:0] clamp, input logic [31:0] accept);
    write_reg(CFG_FIRST_CENTER, centre);
    write_reg(CFG_BIN_STEP, step);
    write_reg(CFG_CLAMP_LEVEL, clamp);
    write_reg(CFG_ACCEPT_LEVEL, accept);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // main sequence
  initial begin : stimulus
    int seg, sent, len;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-bin histograms at the extremes of both parts
    send_bin(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_bin(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    // equally spaced magnitudes: zero divisor, centre returned
    send_amp(2000, 1'b0);
    send_amp(10000, 1'b0);
    send_amp(14000, 1'b0);
    send_amp(14000, 1'b1);
    // plain minimum at the second bin
    send_amp(20000, 1'b0);
    send_amp(8000, 1'b0);
    send_amp(12000, 1'b0);
    send_amp(15000, 1'b0);
    send_amp(15000, 1'b1);
    // bin above the clamp level becomes a zero minimum
    send_amp(10000, 1'b0);
    send_amp(30000, 1'b0);
    send_amp(12000, 1'b0);
    send_amp(12000, 1'b1);
    // minimum would need the bin after the last one
    send_amp(5000, 1'b0);
    send_amp(1000, 1'b0);
    send_amp(9000, 1'b1);
    // two minima, the first one wins
    send_amp(15000, 1'b0);
    send_amp(5000, 1'b0);
    send_amp(9000, 1'b0);
    send_amp(9000, 1'b0);
    send_amp(2000, 1'b0);
    send_amp(9000, 1'b0);
    send_amp(9000, 1'b1);

    // random histograms over several register settings
    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0: load_settings($urandom, $urandom_range(1, 32'h0010_0000),
                         CLAMP_LEVEL_RST, ACCEPT_LEVEL_RST);
        1: load_settings(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: load_settings(32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom);
        3: load_settings($urandom, $urandom, 32'h0000_0000, ACCEPT_LEVEL_RST);
        4: load_settings($urandom, $urandom, $urandom_range(32'h2000_0000, 32'hFFFF_FFFF),
                         32'h0000_0000);
        default: load_settings($urandom, {1'b0, BIN_STEP_RST}, CLAMP_LEVEL_RST,
                               ACCEPT_LEVEL_RST);
      endcase
      // idling pattern per pair of segments
      if (seg < 2) begin
        in_gap_pct    = 36;
        out_stall_pct = 46;
      end else if (seg < 4) begin
        in_gap_pct    = 46;
        out_stall_pct = 36;
      end else begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
      sent = 0;
      while (sent < SEGMENT_BINS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        if ($urandom_range(0, 9) == 0)
          send_noise(len);
        else
          send_valley(len, $urandom_range(0, len - 1));
        sent += len;
      end
      // one histogram running past the bin limit
      if (seg == SEGMENTS - 1) send_valley(MAX_BINS_DEF + 6, MAX_BINS_DEF - 3);
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
